// File: design/integer_set_table_unit_assert.svh
// Assertion macros for the integer set table.
// Included by the top level; clock and reset names are passed in by the user.
`ifndef INTEGER_SET_TABLE_UNIT_ASSERT_SVH
`define INTEGER_SET_TABLE_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define IST_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define IST_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define IST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define IST_ASSERT_ALWAYS(label, clk, rst_n, expr, msg)
`define IST_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define IST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: design/ist_pkg.sv
// Shared constants and types for the integer set table.
// No dependencies; used by ist_cell and integer_set_table_unit.
`timescale 1ns / 1ps
`default_nettype none
package ist_pkg;
    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 4;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    typedef logic signed [31:0] t_word;
    typedef logic [CNT_W-1:0]   t_count;

    // Broadcast to every cell in the row; the add and remove enables travel
    // on their own wires since they depend on the compare result.
    typedef struct packed {
        t_word             value;
        t_count            count;
        logic [POS_W-1:0]  position;
    } t_cell_cmd;
endpackage
`default_nettype wire

// File: design/ist_cell.sv
// One storage cell of the set table: holds an entry, compares, shifts down.
// Depends on ist_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ist_cell (
    input  wire                    i_clk,
    input  ist_pkg::t_cell_cmd     i_cmd,
    input  wire                    i_add_en,
    input  wire                    i_rem_en,
    input  wire [ist_pkg::IDX_W-1:0] i_index,
    input  ist_pkg::t_word         i_next_value,
    input  wire                    i_hit,
    input  ist_pkg::t_word         i_rd,
    output ist_pkg::t_word         o_value,
    output logic                   o_hit,
    output ist_pkg::t_word         o_rd
);
    import ist_pkg::*;

    t_word r_value;
    t_word n_value;
    logic  occupied;
    logic  match;
    logic  pos_sel;

    assign occupied = t_count'(i_index) < i_cmd.count;
    assign match    = occupied && (r_value == i_cmd.value);
    assign pos_sel  = CMP_W'(i_index) == CMP_W'(i_cmd.position);

    // hit ripples down the row: set from the matching cell onward
    assign o_hit   = i_hit | match;
    assign o_rd    = i_rd | (pos_sel ? r_value : '0);
    assign o_value = r_value;

    always_comb begin
        n_value = r_value;
        if (i_rem_en && o_hit) begin
            n_value = i_next_value;
        end else if (i_add_en && (t_count'(i_index) == i_cmd.count)) begin
            n_value = i_cmd.value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end
endmodule
`default_nettype wire

// File: design/integer_set_table_unit.sv
// Top level of the integer set table: a row of ist_cell plus count and result regs.
// Depends on ist_pkg, ist_cell and integer_set_table_unit_assert.svh.
//
//  channel | signals                                   | handshake
//  --------+-------------------------------------------+----------------------
//  command | i_opcode, i_value, i_position             | start high, busy low
//  result  | o_was_present, o_member_count,            | o_valid, one cycle,
//          | o_dropped_full, o_read_value, o_read_valid| no backpressure
//
// One operation per cycle; busy is never raised. The result is registered and appears in the cycle after
// the command beat, set by the compare ripple along the cell row and the count update.
// Reset clears the entry count and the result strobe; entries are not cleared.
// The receiver cannot stall, so nothing is held back.
`timescale 1ns / 1ps
`default_nettype none
`include "integer_set_table_unit_assert.svh"
module integer_set_table_unit (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       start,
    output logic                      busy,
    input  wire [1:0]                 i_opcode,
    input  wire signed [31:0]         i_value,
    input  wire [ist_pkg::POS_W-1:0]  i_position,
    output logic                      o_valid,
    output logic                      o_was_present,
    output logic [4:0]                o_member_count,
    output logic                      o_dropped_full,
    output logic signed [31:0]        o_read_value,
    output logic                      o_read_valid
);
    import ist_pkg::*;

    t_count    r_count;
    t_count    n_count;
    t_cell_cmd cmd;
    logic      add_en;
    logic      rem_en;
    logic      accept;
    logic      present;
    logic      full;
    logic      in_range;
    logic      hit  [0:CAPACITY];
    t_word     rd   [0:CAPACITY];
    t_word     vals [0:CAPACITY-1];

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = r_count == t_count'(CAPACITY);

    assign cmd.value    = i_value;
    assign cmd.count    = r_count;
    assign cmd.position = i_position;
    assign add_en       = accept && (i_opcode == OP_ADD) && !present && !full;
    assign rem_en       = accept && (i_opcode == OP_REMOVE) && present;

    assign hit[0] = 1'b0;
    assign rd[0]  = '0;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            t_word next_value;
            if (g == CAPACITY - 1) begin : g_last
                assign next_value = vals[g];
            end else begin : g_mid
                assign next_value = vals[g+1];
            end
            ist_cell u_cell (
                .i_clk        (i_clk),
                .i_cmd        (cmd),
                .i_add_en     (add_en),
                .i_rem_en     (rem_en),
                .i_index      (IDX_W'(g)),
                .i_next_value (next_value),
                .i_hit        (hit[g]),
                .i_rd         (rd[g]),
                .o_value      (vals[g]),
                .o_hit        (hit[g+1]),
                .o_rd         (rd[g+1])
            );
        end
    endgenerate

    assign present  = hit[CAPACITY];
    assign in_range = CMP_W'(i_position) < CMP_W'(r_count);

    always_comb begin
        n_count = r_count;
        if (add_en) begin
            n_count = r_count + t_count'(1);
        end else if (rem_en) begin
            n_count = r_count - t_count'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            o_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            o_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            o_was_present  <= (i_opcode != OP_READ) && present;
            o_member_count <= 5'(n_count);
            o_dropped_full <= (i_opcode == OP_ADD) && !present && full;
            o_read_value   <= ((i_opcode == OP_READ) && in_range) ? rd[CAPACITY] : '0;
            o_read_valid   <= (i_opcode == OP_READ) && in_range;
        end
    end

    `IST_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= t_count'(CAPACITY),
        "count above capacity")
    `IST_ASSERT_NEXT(a_strobe, i_clk, i_rst_n, accept, o_valid,
        "no result after command beat")
    `IST_ASSERT_IMPLIES(a_drop_full, i_clk, i_rst_n, o_valid && o_dropped_full,
        !o_was_present && (o_member_count == 5'(CAPACITY)), "drop without full store")
    `IST_ASSERT_IMPLIES(a_read_flags, i_clk, i_rst_n, o_valid && o_read_valid,
        !o_was_present && !o_dropped_full, "read result carries set flags")
endmodule
`default_nettype wire

// File: verif/tb_integer_set_table_unit.sv
// Self-checking testbench for integer_set_table_unit: directed and random add, remove,
// query and read commands, each result checked against a running model of the set.
// Depends on ist_pkg and the integer_set_table_unit RTL.
`timescale 1ns / 1ps

typedef struct {
    logic                was_present;
    logic [4:0]          member_count;
    logic                dropped_full;
    ist_pkg::t_word      read_value;
    logic                read_valid;
} t_set_result;

class set_table_scoreboard;
    ist_pkg::t_word held [ist_pkg::CAPACITY];
    int unsigned    held_count;
    t_set_result    pending_results[$];
    int unsigned    mismatches;
    int unsigned    orphans;
    int unsigned    results_seen;
    int unsigned    hits;
    int unsigned    drops;
    int unsigned    good_reads;
    int unsigned    peak_count;

    // Update the set for one accepted command beat and queue its expected result.
    function void note_command(logic [1:0] op, ist_pkg::t_word v, logic [3:0] pos);
        t_set_result exp_r;
        int          slot;
        slot = -1;
        for (int i = 0; i < held_count; i++) begin
            if (slot < 0 && held[i] === v) begin
                slot = i;
            end
        end
        exp_r = '{1'b0, 5'd0, 1'b0, '0, 1'b0};
        case (op)
            ist_pkg::OP_ADD: begin
                exp_r.was_present = (slot >= 0);
                if (slot < 0) begin
                    if (held_count < ist_pkg::CAPACITY) begin
                        held[held_count] = v;
                        held_count++;
                    end else begin
                        exp_r.dropped_full = 1'b1;
                        drops++;
                    end
                end
            end
            ist_pkg::OP_REMOVE: begin
                exp_r.was_present = (slot >= 0);
                if (slot >= 0) begin
                    for (int i = slot; i + 1 < held_count; i++) begin
                        held[i] = held[i + 1];
                    end
                    held_count--;
                end
            end
            ist_pkg::OP_QUERY: begin
                exp_r.was_present = (slot >= 0);
            end
            default: begin
                if (pos < held_count) begin
                    exp_r.read_value = held[pos];
                    exp_r.read_valid = 1'b1;
                    good_reads++;
                end
            end
        endcase
        if (slot >= 0) begin
            hits++;
        end
        if (held_count > peak_count) begin
            peak_count = held_count;
        end
        exp_r.member_count = held_count[4:0];
        pending_results.push_back(exp_r);
    endfunction

    function void check_result(t_set_result got);
        t_set_result exp_r;
        results_seen++;
        if (pending_results.size() == 0) begin
            orphans++;
            $display("[%0t] result beat with nothing expected", $realtime);
            return;
        end
        exp_r = pending_results.pop_front();
        if (got.was_present !== exp_r.was_present || got.member_count !== exp_r.member_count
            || got.dropped_full !== exp_r.dropped_full || got.read_value !== exp_r.read_value
            || got.read_valid !== exp_r.read_valid) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("[%0t] mismatch: exp present=%b count=%0d drop=%b rd=%h rv=%b",
                         $realtime, exp_r.was_present, exp_r.member_count,
                         exp_r.dropped_full, exp_r.read_value, exp_r.read_valid);
                $display("             got present=%b count=%0d drop=%b rd=%h rv=%b",
                         got.was_present, got.member_count, got.dropped_full,
                         got.read_value, got.read_valid);
            end
        end
    endfunction

    function int unsigned outstanding();
        return pending_results.size();
    endfunction

    function bit failed();
        return (mismatches != 0) || (orphans != 0) || (pending_results.size() != 0);
    endfunction
endclass

module tb_integer_set_table_unit;
    import ist_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int POOL_SIZE   = 24;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_opcode;
    t_word       i_value;
    logic [3:0]  i_position;
    logic        o_valid;
    logic        o_was_present;
    logic [4:0]  o_member_count;
    logic        o_dropped_full;
    t_word       o_read_value;
    logic        o_read_valid;

    set_table_scoreboard sb;
    t_word               value_pool [POOL_SIZE];
    int unsigned         cycle_count;
    int unsigned         beats_sent;

    integer_set_table_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_opcode       (i_opcode),
        .i_value        (i_value),
        .i_position     (i_position),
        .o_valid        (o_valid),
        .o_was_present  (o_was_present),
        .o_member_count (o_member_count),
        .o_dropped_full (o_dropped_full),
        .o_read_value   (o_read_value),
        .o_read_valid   (o_read_valid)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Result beat is checked before the command beat of the same edge is noted.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) begin
                sb.check_result('{o_was_present, o_member_count, o_dropped_full,
                                  o_read_value, o_read_valid});
            end
            if (start && !busy) begin
                sb.note_command(i_opcode, i_value, i_position);
            end
        end
    end

    function automatic int unsigned idle_gap(bit calm);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic t_word pick_value();
        if ($urandom_range(0, 9) < 8) begin
            return value_pool[$urandom_range(0, POOL_SIZE - 1)];
        end
        return $urandom;
    endfunction

    // mode 0 grows the set, mode 1 drains it, mode 2 mixes evenly
    function automatic logic [1:0] pick_op(int mode);
        int unsigned r;
        r = $urandom_range(0, 99);
        case (mode)
            0: return (r < 55) ? OP_ADD : (r < 65) ? OP_REMOVE : (r < 80) ? OP_QUERY : OP_READ;
            1: return (r < 10) ? OP_ADD : (r < 65) ? OP_REMOVE : (r < 80) ? OP_QUERY : OP_READ;
            default: return r[1:0];
        endcase
    endfunction

    task automatic send_cmd(logic [1:0] op, t_word v, logic [3:0] pos, int unsigned gap);
        start      <= 1'b1;
        i_opcode   <= op;
        i_value    <= v;
        i_position <= pos;
        do begin
            @(posedge i_clk);
        end while (busy);
        beats_sent++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    initial begin
        int unsigned drain;
        sb          = new();
        cycle_count = 0;
        beats_sent  = 0;
        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_opcode   <= OP_QUERY;
        i_value    <= '0;
        i_position <= '0;

        value_pool[0] = 32'sh7FFF_FFFF;
        value_pool[1] = 32'sh8000_0000;
        value_pool[2] = 32'sd0;
        value_pool[3] = -32'sd1;
        for (int i = 4; i < POOL_SIZE; i++) begin
            // every other value differs from its neighbor in a single bit
            value_pool[i] = (i % 2) ? value_pool[i - 1] ^ (32'h1 << $urandom_range(0, 31))
                                    : t_word'($urandom);
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, duplicate add, hit and miss, shift on remove, full store
        send_cmd(OP_ADD, 32'sh7FFF_FFFF, 4'd0, 0);
        send_cmd(OP_ADD, 32'sh8000_0000, 4'd0, 1);
        send_cmd(OP_ADD, 32'sd0, 4'd0, 0);
        send_cmd(OP_ADD, -32'sd1, 4'd0, 0);
        send_cmd(OP_ADD, 32'sh8000_0000, 4'd0, 2);
        send_cmd(OP_QUERY, 32'sd0, 4'd0, 0);
        send_cmd(OP_QUERY, 32'sd7, 4'd0, 0);
        send_cmd(OP_READ, 32'sd0, 4'd0, 0);
        send_cmd(OP_READ, -32'sd1, 4'd15, 3);
        send_cmd(OP_REMOVE, 32'sd12345, 4'd0, 0);
        send_cmd(OP_REMOVE, 32'sh8000_0000, 4'd0, 0);
        send_cmd(OP_READ, 32'sd0, 4'd1, 0);
        for (int i = 1; i <= 13; i++) begin
            send_cmd(OP_ADD, t_word'(i), 4'd0, idle_gap(1'b0));
        end
        send_cmd(OP_ADD, 32'sd99, 4'hF, 0);
        send_cmd(OP_READ, 32'sd0, 4'd15, 0);

        for (int blk = 0; blk < 16; blk++) begin
            for (int k = 0; k < 100; k++) begin
                send_cmd(pick_op(blk % 3), pick_value(), 4'($urandom_range(0, 15)),
                         idle_gap(blk % 4 == 3));
            end
        end
        start <= 1'b0;

        drain = 0;
        while (sb.outstanding() > 0 && drain < 100) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (4) @(posedge i_clk);

        $display("%0d commands, %0d results; %0d hits, %0d full drops, %0d in-range reads",
                 beats_sent, sb.results_seen, sb.hits, sb.drops, sb.good_reads);
        $display("peak occupancy %0d of %0d, %0d mismatches, %0d unexpected beats",
                 sb.peak_count, CAPACITY, sb.mismatches, sb.orphans);
        if (!sb.failed()) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
